FILE: hdl/wpd_pkg.sv
// ----------------------------------------------------------------------------
// wpd_pkg: shared types and constants for the waveform pulse discriminator
// Widths, register indexes, reset values and the event summary record.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int unsigned SamplesPerEvent = 1024;
  localparam int unsigned IdxW            = $clog2(SamplesPerEvent);

  localparam int unsigned CodeW     = 16;
  localparam int unsigned LevelW    = 17;
  localparam int unsigned MinWidthW = 10;
  localparam int unsigned LimitW    = 27;
  localparam int unsigned CountW    = 10;
  localparam int unsigned FirstW    = 11;
  localparam int unsigned SumW      = 26;

  // start + minimum width must not wrap before the compare
  localparam int unsigned SpanW = ((IdxW > MinWidthW) ? IdxW : MinWidthW) + 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = LimitW;

  localparam logic [CfgIdxW-1:0] CFG_TRIG_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAL_LIMIT  = 2'd2;

  localparam logic [LevelW-1:0]    TrigLevelRst = 17'd39321;
  localparam logic [MinWidthW-1:0] MinWidthRst  = 10'd7;
  localparam logic [LimitW-1:0]    CalLimitRst  = 27'd13107000;

  localparam logic [CountW-1:0] CountMax   = '1;
  localparam logic [CodeW-1:0]  FullScale  = '1;

  localparam int unsigned InDataW  = 2 * CodeW;
  localparam int unsigned OutDataW = 24;

  // what the sample accumulator hands on at the end of an event
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [FirstW-1:0] first_start;
    logic [SumW-1:0]   cal_sum;
    logic [IdxW:0]     n_samples;
  } evt_summary_t;

endpackage

FILE: hdl/wpd_event_acc.sv
// ----------------------------------------------------------------------------
// wpd_event_acc: per-sample event state
// Tracks the armed pulse, qualified pulse count, first start and the
// calibration sum; presents the event summary on the closing sample.
// ----------------------------------------------------------------------------
module wpd_event_acc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [wpd_pkg::CodeW-1:0]        trig_i,
  input  logic [wpd_pkg::CodeW-1:0]        cal_i,
  input  logic                             last_i,
  input  logic [wpd_pkg::LevelW-1:0]       trig_level_i,
  input  logic [wpd_pkg::MinWidthW-1:0]    min_width_i,
  output logic                             done_o,
  output wpd_pkg::evt_summary_t            summary_o
);

  logic [wpd_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                       armed_q, armed_d;
  logic [wpd_pkg::IdxW-1:0]   start_q, start_d;
  logic [wpd_pkg::CountW-1:0] count_q, count_d;
  logic [wpd_pkg::FirstW-1:0] first_q, first_d;
  logic [wpd_pkg::SumW-1:0]   sum_q, sum_d;

  logic [wpd_pkg::LevelW-1:0] twice;
  logic [wpd_pkg::SpanW-1:0]  span_end;
  logic                       wide_enough;
  logic                       end_evt;

  assign twice    = {trig_i, 1'b0};
  assign span_end = wpd_pkg::SpanW'(start_q) + wpd_pkg::SpanW'(min_width_i);
  assign wide_enough = span_end < wpd_pkg::SpanW'(idx_q);
  assign end_evt  = last_i || (idx_q == wpd_pkg::IdxW'(wpd_pkg::SamplesPerEvent - 1));

  always_comb begin
    armed_d = armed_q;
    start_d = start_q;
    count_d = count_q;
    first_d = first_q;
    if (!armed_q && (twice < trig_level_i)) begin
      armed_d = 1'b1;
      start_d = idx_q;
    end else if (armed_q && (twice > trig_level_i)) begin
      armed_d = 1'b0;
      if (wide_enough) begin
        if (count_q == '0) begin
          first_d = wpd_pkg::FirstW'(start_q);
        end
        if (count_q != wpd_pkg::CountMax) begin
          count_d = count_q + 1'b1;
        end
      end
    end
    sum_d = sum_q + wpd_pkg::SumW'(cal_i);
    idx_d = idx_q + 1'b1;
  end

  assign done_o                = step_i && end_evt;
  assign summary_o.count       = count_d;
  assign summary_o.first_start = first_d;
  assign summary_o.cal_sum     = sum_d;
  assign summary_o.n_samples   = {1'b0, idx_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      armed_q <= 1'b0;
      start_q <= '0;
      count_q <= '0;
      first_q <= '1;
      sum_q   <= '0;
    end else if (step_i) begin
      if (end_evt) begin
        idx_q   <= '0;
        armed_q <= 1'b0;
        start_q <= '0;
        count_q <= '0;
        first_q <= '1;
        sum_q   <= '0;
      end else begin
        idx_q   <= idx_d;
        armed_q <= armed_d;
        start_q <= start_d;
        count_q <= count_d;
        first_q <= first_d;
        sum_q   <= sum_d;
      end
    end
  end

endmodule

FILE: hdl/waveform_pulse_discriminator.sv
// ----------------------------------------------------------------------------
// waveform_pulse_discriminator: leading-edge discriminator with minimum width
// Counts trigger pulses per event and checks the calibration channel sum.
// ----------------------------------------------------------------------------
// One sample beat can be taken every cycle while s_axis_tready is high. The
// per-sample state update sits between the input register and the summary
// register, and the calibration deviation compare takes one more stage,
// ending in the output register that drives m_axis_tvalid. An event closes
// on tlast or at its 1024th sample. The output holds two result slots.
// s_axis_tready drops only once both are full, and it is driven from a
// register, not from m_axis_tready. Samples that close no event keep flowing
// while a single result waits.
module waveform_pulse_discriminator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wpd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wpd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wpd_pkg::InDataW-1:0]       s_axis_tdata,  // trig_sample, calib_sample
  input  logic                              s_axis_tlast,  // last_sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wpd_pkg::OutDataW-1:0]      m_axis_tdata   // pulse_count, first_pulse_start,
                                                           // calib_flag, zero pad
);

  logic [wpd_pkg::LevelW-1:0]    trig_level_q;
  logic [wpd_pkg::MinWidthW-1:0] min_width_q;
  logic [wpd_pkg::LimitW-1:0]    cal_limit_q;

  logic                       pipe_en;
  logic                       in_valid_q;
  logic [wpd_pkg::CodeW-1:0]  trig_q, cal_q;
  logic                       last_q;
  logic                       step;

  logic                       done;
  wpd_pkg::evt_summary_t      summary, summary_q;
  logic                       sum_valid_q;

  logic [wpd_pkg::LimitW-1:0] twice_sum, mid_total, dev;
  logic                       flag;

  logic                       out_free;
  logic                       new_res;
  logic                       out_valid_q;
  logic [wpd_pkg::CountW-1:0] out_count_q;
  logic [wpd_pkg::FirstW-1:0] out_first_q;
  logic                       out_flag_q;
  logic                       skid_valid_q;
  logic [wpd_pkg::CountW-1:0] skid_count_q;
  logic [wpd_pkg::FirstW-1:0] skid_first_q;
  logic                       skid_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_level_q <= wpd_pkg::TrigLevelRst;
      min_width_q  <= wpd_pkg::MinWidthRst;
      cal_limit_q  <= wpd_pkg::CalLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wpd_pkg::CFG_TRIG_LEVEL: trig_level_q <= cfg_wdata_i[wpd_pkg::LevelW-1:0];
        wpd_pkg::CFG_MIN_WIDTH:  min_width_q  <= cfg_wdata_i[wpd_pkg::MinWidthW-1:0];
        wpd_pkg::CFG_CAL_LIMIT:  cal_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // whole pipe moves unless both output slots are taken
  assign pipe_en       = !skid_valid_q;
  assign s_axis_tready = pipe_en;
  assign step          = in_valid_q && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pipe_en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && s_axis_tvalid) begin
      trig_q <= s_axis_tdata[wpd_pkg::CodeW-1:0];
      cal_q  <= s_axis_tdata[2*wpd_pkg::CodeW-1:wpd_pkg::CodeW];
      last_q <= s_axis_tlast;
    end
  end

  wpd_event_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .trig_i       (trig_q),
    .cal_i        (cal_q),
    .last_i       (last_q),
    .trig_level_i (trig_level_q),
    .min_width_i  (min_width_q),
    .done_o       (done),
    .summary_o    (summary)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (pipe_en) begin
      sum_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      summary_q <= summary;
    end
  end

  // |2*sum - n*full_scale|, with n*65535 as (n << 16) - n
  assign twice_sum = {summary_q.cal_sum, 1'b0};
  assign mid_total = (wpd_pkg::LimitW'(summary_q.n_samples) << wpd_pkg::CodeW)
                   - wpd_pkg::LimitW'(summary_q.n_samples);
  assign dev       = (twice_sum > mid_total) ? (twice_sum - mid_total)
                                             : (mid_total - twice_sum);
  assign flag      = dev > cal_limit_q;

  // output slot plus a spare slot that catches a result while the first waits
  assign out_free = !out_valid_q || m_axis_tready;
  assign new_res  = pipe_en && sum_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || new_res;
      skid_valid_q <= 1'b0;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_count_q <= skid_count_q;
        out_first_q <= skid_first_q;
        out_flag_q  <= skid_flag_q;
      end else if (new_res) begin
        out_count_q <= summary_q.count;
        out_first_q <= summary_q.first_start;
        out_flag_q  <= flag;
      end
    end else if (new_res) begin
      skid_count_q <= summary_q.count;
      skid_first_q <= summary_q.first_start;
      skid_flag_q  <= flag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = wpd_pkg::OutDataW'({out_flag_q, out_first_q, out_count_q});

endmodule
